[rtl/core/integer_to_decimal_ascii_top_defines.svh]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII - assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and quiet during reset
`define I2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and quiet during reset
`define I2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/i2d_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII - package
// Payload types, sequencer states, control bundle and character constants.
// ----------------------------------------------------------------------------
package i2d_pkg;

	localparam int ValueBits = 32;
	localparam int CharBits  = 8;
	localparam int CountBits = 4;
	localparam int DigitBits = 4;

	localparam logic [CharBits-1:0]  CharZero  = 8'd48;
	localparam logic [CharBits-1:0]  CharMinus = 8'd45;
	localparam logic [DigitBits-1:0] DigitMax  = 4'd9;
	// shift-add-3: a BCD digit of five or more is corrected before the shift
	localparam logic [DigitBits-1:0] DabbleLimit = 4'd5;
	localparam logic [DigitBits-1:0] DabbleAdj   = 4'd3;

	typedef struct packed {
		logic [ValueBits-1:0] value;
		logic                 func;
	} req_t;

	typedef struct packed {
		logic [CharBits-1:0]  out_char;
		logic                 last;
		logic [CountBits-1:0] char_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;         // take a fresh magnitude, clear the BCD word
		logic step;         // one shift-add-3 iteration
		logic shift_digit;  // drop the top BCD digit
	} dab_ctl_t;

endpackage

[rtl/core/i2d_dabble.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII - shift-add-3 unit
// Binary and BCD shift registers with one shared correction-and-shift step.
// ----------------------------------------------------------------------------
module i2d_dabble #(
	parameter int VALUE_WIDTH = 32,
	parameter int NUM_DIGITS  = 10
) (
	input  logic                                       clk,
	input  i2d_pkg::dab_ctl_t                          ctl,
	input  logic [VALUE_WIDTH-1:0]                     mag,
	output logic [i2d_pkg::DigitBits-1:0]              top_digit
);

	localparam int BcdBits = NUM_DIGITS * i2d_pkg::DigitBits;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BcdBits-1:0]     bcd_q;
	logic [BcdBits-1:0]     bcd_adj;

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*i2d_pkg::DigitBits +: i2d_pkg::DigitBits] >= i2d_pkg::DabbleLimit) begin
				bcd_adj[i*i2d_pkg::DigitBits +: i2d_pkg::DigitBits] =
					bcd_q[i*i2d_pkg::DigitBits +: i2d_pkg::DigitBits] + i2d_pkg::DabbleAdj;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BcdBits-2:0], bin_q[VALUE_WIDTH-1]};
		end else if (ctl.shift_digit) begin
			bcd_q <= {bcd_q[BcdBits-i2d_pkg::DigitBits-1:0], {i2d_pkg::DigitBits{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BcdBits-1 -: i2d_pkg::DigitBits];

endmodule

[rtl/core/i2d_ctrl.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII - sequencer
// Runs conversion, strips leading zeros and issues one character per slot.
// ----------------------------------------------------------------------------
module i2d_ctrl #(
	parameter int VALUE_WIDTH = 32,
	parameter int NUM_DIGITS  = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          negative,
	input  logic [i2d_pkg::DigitBits-1:0] top_digit,
	input  logic                          rsp_free,
	output logic                          req_stall,
	output i2d_pkg::dab_ctl_t             ctl,
	output logic                          emit,
	output i2d_pkg::rsp_t                 emit_data
);

	localparam int BitCntBits = $clog2(VALUE_WIDTH);
	localparam int DigCntBits = $clog2(NUM_DIGITS + 1);

	i2d_pkg::state_t state_q, state_d;

	logic [BitCntBits-1:0]         bit_cnt_q;
	logic [DigCntBits-1:0]         dig_cnt_q;
	logic [i2d_pkg::CountBits-1:0] char_cnt_q;
	logic                          neg_q;

	logic conv_done;
	logic trim_done;
	logic last_digit;

	assign conv_done  = (bit_cnt_q == BitCntBits'(VALUE_WIDTH - 1));
	assign trim_done  = (top_digit != '0) || (dig_cnt_q == DigCntBits'(1));
	assign last_digit = (dig_cnt_q == DigCntBits'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2d_pkg::ST_IDLE: begin
				if (req_valid) state_d = i2d_pkg::ST_CONV;
			end
			i2d_pkg::ST_CONV: begin
				if (conv_done) state_d = i2d_pkg::ST_TRIM;
			end
			i2d_pkg::ST_TRIM: begin
				if (trim_done) state_d = neg_q ? i2d_pkg::ST_SIGN : i2d_pkg::ST_EMIT;
			end
			i2d_pkg::ST_SIGN: begin
				if (rsp_free) state_d = i2d_pkg::ST_EMIT;
			end
			i2d_pkg::ST_EMIT: begin
				if (rsp_free && last_digit) state_d = i2d_pkg::ST_IDLE;
			end
			default: state_d = i2d_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall            = 1'b1;
		ctl                  = '0;
		emit                 = 1'b0;
		emit_data.out_char   = i2d_pkg::CharZero + {{(i2d_pkg::CharBits-i2d_pkg::DigitBits){1'b0}},
			top_digit};
		emit_data.last       = 1'b0;
		emit_data.char_count = '0;
		unique case (state_q)
			i2d_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				ctl.load  = req_valid;
			end
			i2d_pkg::ST_CONV: begin
				ctl.step = 1'b1;
			end
			i2d_pkg::ST_TRIM: begin
				ctl.shift_digit = !trim_done;
			end
			i2d_pkg::ST_SIGN: begin
				emit               = rsp_free;
				emit_data.out_char = i2d_pkg::CharMinus;
			end
			i2d_pkg::ST_EMIT: begin
				emit            = rsp_free;
				ctl.shift_digit = rsp_free;
				emit_data.last  = last_digit;
				if (last_digit) emit_data.char_count = char_cnt_q + 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= i2d_pkg::ST_IDLE;
			bit_cnt_q  <= '0;
			dig_cnt_q  <= '0;
			char_cnt_q <= '0;
			neg_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				bit_cnt_q  <= '0;
				dig_cnt_q  <= DigCntBits'(NUM_DIGITS);
				char_cnt_q <= '0;
				neg_q      <= negative;
			end else begin
				if (ctl.step) bit_cnt_q <= bit_cnt_q + 1'b1;
				if (ctl.shift_digit) dig_cnt_q <= dig_cnt_q - 1'b1;
				if (emit) char_cnt_q <= char_cnt_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/integer_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// Integer to decimal ASCII - top level
// Prints a binary word as decimal text, one character per response.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  request | req_valid, req_stall | req (value, func)
//  respond | rsp_valid, rsp_stall | rsp (out_char, last, char_count)
//
//  One request is loaded, run through VALUE_WIDTH shift-add-3 steps, stripped
//  of leading zero digits, then printed as a minus sign first if negative and
//  one character per response, and the sequencer then returns to idle.
//  req_stall is high from acceptance until the last character is registered.
//  A stalled response holds the sequencer in place; nothing is dropped.
//  Reset returns the sequencer to idle and empties the response register.
// ----------------------------------------------------------------------------
`include "integer_to_decimal_ascii_top_defines.svh"

module integer_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  i2d_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output i2d_pkg::rsp_t rsp
);

	localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int CopyBits  = (VALUE_WIDTH < i2d_pkg::ValueBits) ? VALUE_WIDTH
		: i2d_pkg::ValueBits;

	logic [VALUE_WIDTH-1:0]          word;
	logic [VALUE_WIDTH-1:0]          mag;
	logic                            negative;
	logic [i2d_pkg::DigitBits-1:0]   top_digit;
	logic                            rsp_free;
	logic                            emit;
	i2d_pkg::rsp_t                   emit_data;
	i2d_pkg::dab_ctl_t               ctl;

	logic          rsp_valid_q;
	i2d_pkg::rsp_t rsp_q;

	always_comb begin
		word                 = '0;
		word[CopyBits-1:0]   = req.value[CopyBits-1:0];
	end

	assign negative = req.func & word[VALUE_WIDTH-1];
	// two's complement negation read as unsigned covers the most negative word
	assign mag      = negative ? VALUE_WIDTH'(~word + VALUE_WIDTH'(1)) : word;

	i2d_dabble #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_DIGITS  (NumDigits)
	) u_dabble (
		.clk       (clk),
		.ctl       (ctl),
		.mag       (mag),
		.top_digit (top_digit)
	);

	i2d_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_DIGITS  (NumDigits)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.negative  (negative),
		.top_digit (top_digit),
		.rsp_free  (rsp_free),
		.req_stall (req_stall),
		.ctl       (ctl),
		.emit      (emit),
		.emit_data (emit_data)
	);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) rsp_q <= emit_data;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`I2D_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall,
		"sequencer accepted a request but is not busy")
	`I2D_ASSERT_NOW(a_minus_not_last, rsp_valid && rsp.out_char == i2d_pkg::CharMinus,
		!rsp.last, "minus sign flagged as final character")
	`I2D_ASSERT_NOW(a_count_only_last, rsp_valid && !rsp.last, rsp.char_count == '0,
		"character count on a non-final character")
	`I2D_ASSERT_NOW(a_char_is_digit, rsp_valid && rsp.out_char != i2d_pkg::CharMinus,
		rsp.out_char >= i2d_pkg::CharZero &&
		rsp.out_char <= i2d_pkg::CharZero + i2d_pkg::CharBits'(i2d_pkg::DigitMax),
		"response character outside the decimal digits")

endmodule

[dv/decimal_text_checker.sv]
// ----------------------------------------------------------------------------
// Decimal text checker
// Watches both channels of the decimal ASCII printer. Every request taken
// is spelled out into the characters it must produce, and every character
// returned is compared field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module decimal_text_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  i2d_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  i2d_pkg::rsp_t rsp,
	output int            fail_count,
	output int            chars_owed,
	output int            numbers_taken,
	output int            negatives_taken,
	output int            chars_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Radix = 10;
	localparam int MaxDigits = 24;

	i2d_pkg::rsp_t owed_chars[$];

	initial begin
		fail_count      = 0;
		chars_owed      = 0;
		numbers_taken   = 0;
		negatives_taken = 0;
		chars_checked   = 0;
	end

	// Push the full decimal text of one request, most significant digit first
	function automatic void spell_decimal(input i2d_pkg::req_t r);
		logic [i2d_pkg::ValueBits-1:0] magnitude;
		logic [i2d_pkg::DigitBits-1:0] digit_stack [0:MaxDigits-1];
		int                            n_digits;
		int                            total;
		logic                          negative;
		i2d_pkg::rsp_t                 ch;
		negative  = r.func && r.value[i2d_pkg::ValueBits-1];
		// the most negative word wraps back onto itself, which is its true magnitude
		magnitude = negative ? (~r.value + 1'b1) : r.value;
		n_digits  = 0;
		do begin
			digit_stack[n_digits] = i2d_pkg::DigitBits'(magnitude % Radix);
			magnitude = magnitude / Radix;
			n_digits++;
		end while (magnitude != 0);
		total = n_digits + (negative ? 1 : 0);
		if (negative) begin
			ch.out_char   = i2d_pkg::CharMinus;
			ch.last       = 1'b0;
			ch.char_count = '0;
			owed_chars.push_back(ch);
			negatives_taken++;
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			ch.out_char   = i2d_pkg::CharZero + i2d_pkg::CharBits'(digit_stack[i]);
			ch.last       = (i == 0);
			ch.char_count = (i == 0) ? total[i2d_pkg::CountBits-1:0] : '0;
			owed_chars.push_back(ch);
		end
	endfunction

	// Inputs and outputs only move at the rising edge, so the falling edge
	// sees exactly what the next rising edge will take.
	always @(negedge clk) begin
		i2d_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				spell_decimal(req);
				numbers_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				chars_checked++;
				if (owed_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual '%s' last=%0b count=%0d",
						$time, rsp.out_char, rsp.last, rsp.char_count);
					fail_count++;
				end else begin
					want = owed_chars.pop_front();
					if (rsp.out_char !== want.out_char) begin
						$display("%0t: out_char mismatch: expected %0d, actual %0d",
							$time, want.out_char, rsp.out_char);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, rsp.last);
						fail_count++;
					end
					if (rsp.char_count !== want.char_count) begin
						$display("%0t: char_count mismatch: expected %0d, actual %0d",
							$time, want.char_count, rsp.char_count);
						fail_count++;
					end
				end
			end
			chars_owed = owed_chars.size();
		end
	end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Decimal ASCII printer testbench
// Drives signed and unsigned words through the printer with random idle
// bursts on both channels and one long response hold-off, and leaves the
// checking of every character to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 400;
	localparam int CalmItems   = 60;
	localparam int HoldItem    = 150;
	localparam int HoldCycles  = 300;
	localparam int DrainCycles = 80;
	localparam int CycleLimit  = 400000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	i2d_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	i2d_pkg::rsp_t rsp;

	int   fail_count;
	int   chars_owed;
	int   numbers_taken;
	int   negatives_taken;
	int   chars_checked;
	int   cycle_count = 0;
	bit   calm        = 1'b0;
	bit   long_hold   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_to_decimal_ascii_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	decimal_text_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.chars_owed      (chars_owed),
		.numbers_taken   (numbers_taken),
		.negatives_taken (negatives_taken),
		.chars_checked   (chars_checked)
	);

	// Offer one request, hold it until taken, then maybe idle for a burst
	task automatic offer_number(input logic [i2d_pkg::ValueBits-1:0] value,
		input logic func);
		bit            taken;
		i2d_pkg::req_t r;
		r.value   = value;
		r.func    = func;
		req       <= r;
		req_valid <= 1'b1;
		forever begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
			if (taken)
				break;
		end
		if (!calm && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Spread values over every text length, sign and edge of the range
	function automatic i2d_pkg::req_t draw_number();
		i2d_pkg::req_t   r;
		longint unsigned span;
		longint unsigned pick;
		int              digits;
		r.func = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				r.value = $urandom;
			end
			4, 5, 6: begin
				digits = $urandom_range(1, 10);
				span   = 1;
				repeat (digits) span *= 10;
				pick    = {$urandom, $urandom} % span;
				r.value = pick[i2d_pkg::ValueBits-1:0];
				if (r.func && $urandom_range(0, 1))
					r.value = -r.value;
			end
			7: begin
				digits = $urandom_range(0, 9);
				span   = 1;
				repeat (digits) span *= 10;
				r.value = span[i2d_pkg::ValueBits-1:0] + $urandom_range(0, 2) - 1;
				if (r.func && $urandom_range(0, 1))
					r.value = -r.value;
			end
			8: begin
				r.value = $urandom_range(0, 20);
			end
			default: begin
				case ($urandom_range(0, 3))
					0:       r.value = 32'h7FFF_FFFF - $urandom_range(0, 3);
					1:       r.value = 32'h8000_0000 + $urandom_range(0, 3);
					2:       r.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
					default: r.value = $urandom_range(0, 3);
				endcase
			end
		endcase
		return r;
	endfunction

	// Response side: short stall bursts, stall-free stretches, one long hold-off
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		i2d_pkg::req_t r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero in both modes, short and long texts, the signed extremes
		offer_number(32'd0, 1'b0);
		offer_number(32'd0, 1'b1);
		offer_number(32'd1, 1'b0);
		offer_number(32'd9, 1'b1);
		offer_number(32'd10, 1'b0);
		offer_number(32'd99, 1'b1);
		offer_number(32'd100, 1'b0);
		offer_number(32'd999_999_999, 1'b0);
		offer_number(32'd1_000_000_000, 1'b1);
		offer_number(32'hFFFF_FFFF, 1'b0);
		offer_number(32'hFFFF_FFFF, 1'b1);
		offer_number(32'h8000_0000, 1'b1);
		offer_number(32'h8000_0000, 1'b0);
		offer_number(32'h7FFF_FFFF, 1'b1);
		offer_number(32'h7FFF_FFFF, 1'b0);
		offer_number(32'h8000_0001, 1'b1);
		offer_number(-32'sd10, 1'b1);
		offer_number(-32'sd10, 1'b0);
		offer_number(32'hAAAA_AAAA, 1'b1);
		offer_number(32'h5555_5555, 1'b1);

		for (int n = 0; n < RandomItems; n++) begin
			if (n == HoldItem)
				long_hold = 1'b1;
			if (n == RandomItems - CalmItems)
				calm = 1'b1;
			r = draw_number();
			offer_number(r.value, r.func);
		end
		req_valid <= 1'b0;

		while (chars_owed != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Printed %0d numbers (%0d of them negative) as %0d characters in %0d cycles",
			numbers_taken, negatives_taken, chars_checked, cycle_count);
		$display("Both channels idled in bursts, with one long response hold-off");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/i2d_pkg.sv
rtl/core/i2d_dabble.sv
rtl/core/i2d_ctrl.sv
rtl/core/integer_to_decimal_ascii_top.sv
dv/decimal_text_checker.sv
dv/tb_top.sv
